### design/transactional_counter_table_macros.svh
`ifndef TRANSACTIONAL_COUNTER_TABLE_MACROS_SVH
`define TRANSACTIONAL_COUNTER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define TCT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transactional_counter_table: check failed");

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define TCT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transactional_counter_table: check failed");

`endif

### design/tct_pkg.sv
`timescale 1ns / 1ps

package tct_pkg;

   localparam int TERM_TYPES     = 8;
   localparam int TERMS_PER_TYPE = 4096;
   localparam int BATCH_MAX      = 256;

   localparam int STORE_DEPTH = TERM_TYPES * TERMS_PER_TYPE;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int JIDX_W      = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int JFILL_W     = $clog2(BATCH_MAX + 1);

   localparam int CMD_W    = 2;
   localparam int TYPE_W   = 8;
   localparam int TERM_W   = 20;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_INC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TYPE_RANGE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TERM_ZERO    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TERM_CAP     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_JOURNAL_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SKIPPED      = 3'd5;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
   } jentry_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [VALUE_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr;
   } store_port_type;

   typedef struct packed {
      logic              we;
      logic [JIDX_W-1:0] waddr;
      jentry_type        wdata;
      logic [JIDX_W-1:0] raddr;
   } journal_port_type;

   function automatic logic [STATUS_W-1:0] check_address(
      input logic [TYPE_W-1:0] type_in,
      input logic [TERM_W-1:0] term_in
   );
      logic [STATUS_W-1:0] res;
      res = ST_OK;
      if (type_in == '0 || 32'(type_in) > 32'(TERM_TYPES))
         res = ST_TYPE_RANGE;
      else if (term_in == '0)
         res = ST_TERM_ZERO;
      else if (32'(term_in) > 32'(TERMS_PER_TYPE))
         res = ST_TERM_CAP;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] address_of(
      input logic [TYPE_W-1:0] type_in,
      input logic [TERM_W-1:0] term_in
   );
      logic [31:0] lin;
      lin = 32'(type_in - 8'd1) * 32'(TERMS_PER_TYPE) + 32'(term_in - 20'd1);
      return lin[ADDR_W-1:0];
   endfunction

endpackage

### design/tct_ram.sv
`timescale 1ns / 1ps

module tct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/tct_ctrl.sv
`timescale 1ns / 1ps

module tct_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tct_pkg::CMD_W-1:0]        req_command,
   input  logic [tct_pkg::TYPE_W-1:0]       req_type_number,
   input  logic [tct_pkg::TERM_W-1:0]       req_term_number,
   input  logic signed [tct_pkg::VALUE_W-1:0] req_increment_value,
   input  logic                             req_batch_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tct_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [tct_pkg::VALUE_W-1:0] rsp_count,
   output logic                             rsp_batch_reverted,
   output tct_pkg::store_port_type          store_port,
   input  logic [tct_pkg::VALUE_W-1:0]      store_rdata,
   output tct_pkg::journal_port_type        journal_port,
   input  tct_pkg::jentry_type              journal_rdata
);

   import tct_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_UPDATE,
      S_LOOKUP,
      S_RB_JREAD,
      S_RB_SREAD,
      S_RB_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [JFILL_W-1:0]  fill_ff, fill_in;
   logic                skip_ff, skip_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                report_ff, report_in;
   logic [JFILL_W-1:0]  rb_idx_ff, rb_idx_in;
   jentry_type          rb_entry_ff, rb_entry_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                last_ff, last_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_count_ff, res_count_in;
   logic                res_rev_ff, res_rev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_rev_ff, rsp_rev_in;

   logic [STATUS_W-1:0] chk;
   logic [STATUS_W-1:0] inc_status;
   logic [ADDR_W-1:0]   req_addr;
   logic [JFILL_W-1:0]  rb_next;
   logic                done_now;
   logic                out_free;

   assign chk      = check_address(req_type_number, req_term_number);
   assign req_addr = address_of(req_type_number, req_term_number);
   assign inc_status = (chk == ST_OK && fill_ff >= JFILL_W'(BATCH_MAX)) ?
                       ST_JOURNAL_FULL : chk;
   assign rb_next  = rb_idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      skip_in       = skip_ff;
      sweep_in      = sweep_ff;
      report_in     = report_ff;
      rb_idx_in     = rb_idx_ff;
      rb_entry_in   = rb_entry_ff;
      addr_in       = addr_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_rev_in    = res_rev_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      done_now      = 1'b0;
      store_port    = '0;
      journal_port  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            store_port.we    = 1'b1;
            store_port.waddr = sweep_ff;
            sweep_in         = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
               if (report_ff) begin
                  report_in     = 1'b0;
                  res_status_in = ST_OK;
                  res_count_in  = '0;
                  res_rev_in    = 1'b0;
                  done_now      = 1'b1;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               addr_in       = req_addr;
               value_in      = req_increment_value;
               last_in       = req_batch_last;
               res_status_in = ST_OK;
               res_count_in  = '0;
               res_rev_in    = 1'b0;
               store_port.raddr = req_addr;
               unique case (req_command)
                  CMD_INC: begin
                     if (skip_ff) begin
                        res_status_in = ST_SKIPPED;
                        if (req_batch_last) skip_in = 1'b0;
                        done_now = 1'b1;
                     end else if (inc_status != ST_OK) begin
                        res_status_in = inc_status;
                        res_rev_in    = (fill_ff != '0);
                        if (!req_batch_last) skip_in = 1'b1;
                        if (fill_ff != '0) begin
                           rb_idx_in = '0;
                           state_in  = S_RB_JREAD;
                        end else begin
                           done_now = 1'b1;
                        end
                     end else begin
                        state_in = S_UPDATE;
                     end
                  end
                  CMD_QUERY: begin
                     if (chk == ST_TYPE_RANGE || chk == ST_TERM_ZERO) begin
                        res_status_in = chk;
                        done_now      = 1'b1;
                     end else if (chk == ST_TERM_CAP) begin
                        done_now = 1'b1;
                     end else begin
                        state_in = S_LOOKUP;
                     end
                  end
                  CMD_CLEAR: begin
                     // the open batch can no longer be reverted
                     fill_in   = '0;
                     sweep_in  = '0;
                     report_in = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  default: begin
                     done_now = 1'b1;
                  end
               endcase
            end
         end
         S_UPDATE: begin
            store_port.we      = 1'b1;
            store_port.waddr   = addr_ff;
            store_port.wdata   = store_rdata + value_ff;
            journal_port.we    = 1'b1;
            journal_port.waddr = fill_ff[JIDX_W-1:0];
            journal_port.wdata = '{addr: addr_ff, value: value_ff};
            fill_in  = last_ff ? '0 : fill_ff + 1'b1;
            state_in = S_IDLE;
            done_now = 1'b1;
         end
         S_LOOKUP: begin
            res_count_in = store_rdata;
            state_in     = S_IDLE;
            done_now     = 1'b1;
         end
         S_RB_JREAD: begin
            journal_port.raddr = rb_idx_ff[JIDX_W-1:0];
            state_in           = S_RB_SREAD;
         end
         S_RB_SREAD: begin
            rb_entry_in      = journal_rdata;
            store_port.raddr = journal_rdata.addr;
            state_in         = S_RB_WRITE;
         end
         S_RB_WRITE: begin
            store_port.we    = 1'b1;
            store_port.waddr = rb_entry_ff.addr;
            store_port.wdata = store_rdata - rb_entry_ff.value;
            rb_idx_in        = rb_next;
            if (rb_next == fill_ff) begin
               fill_in  = '0;
               state_in = S_IDLE;
               done_now = 1'b1;
            end else begin
               state_in = S_RB_JREAD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            done_now = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the result over, or park it until the output word drains
      if (done_now) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_in;
            rsp_count_in  = res_count_in;
            rsp_rev_in    = res_rev_in;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         fill_ff      <= '0;
         skip_ff      <= 1'b0;
         sweep_ff     <= '0;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         sweep_ff     <= sweep_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rb_idx_ff     <= rb_idx_in;
      rb_entry_ff   <= rb_entry_in;
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_rev_ff    <= res_rev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rev_ff    <= rsp_rev_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_batch_reverted = rsp_rev_ff;

endmodule

### design/transactional_counter_table.sv
`timescale 1ns / 1ps

// Transactional counter table: one signed 32-bit counter per (type, term) pair, held in a
// single-port-read synchronous memory, plus a batch journal memory that logs every increment
// of the open batch so that the first failing increment can subtract them back out. Every
// request word returns exactly one response word. The counter memory read is registered: an
// increment or an in-range query reads the counter, then writes it back or returns it; a
// rejected, skipped or no-operation word and a query that needs no read answer straight from
// idle; a failing increment rolls back each logged entry by a journal read, a counter read and
// a counter write; a clear writes every counter in turn. After reset a clearing pass zeroes all
// STORE_DEPTH (32768) counters, and req_stall stays high until it is over. A result that meets
// a stalled response port is parked in the controller, with req_stall held high, until the
// response register drains.

module transactional_counter_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tct_pkg::CMD_W-1:0]        req_command,
   input  logic [tct_pkg::TYPE_W-1:0]       req_type_number,
   input  logic [tct_pkg::TERM_W-1:0]       req_term_number,
   input  logic signed [tct_pkg::VALUE_W-1:0] req_increment_value,
   input  logic                             req_batch_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tct_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [tct_pkg::VALUE_W-1:0] rsp_count,
   output logic                             rsp_batch_reverted
);

   import tct_pkg::*;

   store_port_type     store_port;
   journal_port_type   journal_port;
   logic [VALUE_W-1:0] store_rdata;
   jentry_type         journal_rdata;

   // Sequencer: check, read-modify-write, rollback walk, clearing sweep, response register.
   tct_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_type_number     (req_type_number),
      .req_term_number     (req_term_number),
      .req_increment_value (req_increment_value),
      .req_batch_last      (req_batch_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_count           (rsp_count),
      .rsp_batch_reverted  (rsp_batch_reverted),
      .store_port          (store_port),
      .store_rdata         (store_rdata),
      .journal_port        (journal_port),
      .journal_rdata       (journal_rdata)
   );

   // Counter memory: one counter per (type, term), zeroed by the sweep.
   tct_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (store_port.we),
      .waddr (store_port.waddr),
      .wdata (store_port.wdata),
      .raddr (store_port.raddr),
      .rdata (store_rdata)
   );

   // Journal memory: only entries below the fill count are ever read back.
   tct_ram #(
      .WIDTH ($bits(jentry_type)),
      .DEPTH (BATCH_MAX)
   ) u_journal (
      .clock (clock),
      .we    (journal_port.we),
      .waddr (journal_port.waddr),
      .wdata (journal_port.wdata),
      .raddr (journal_port.raddr),
      .rdata (journal_rdata)
   );

endmodule

### design/tct_checker.sv
`timescale 1ns / 1ps
`include "transactional_counter_table_macros.svh"

module tct_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tct_pkg::STATUS_W-1:0]     rsp_status,
   input logic signed [tct_pkg::VALUE_W-1:0] rsp_count,
   input logic                             rsp_batch_reverted
);

   import tct_pkg::*;

   logic [STATUS_W+VALUE_W:0] rsp_word;
   logic                      rsp_held;
   logic                      rsp_fail;

   assign rsp_word = {rsp_status, rsp_count, rsp_batch_reverted};
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_fail = (rsp_status != ST_OK) && (rsp_status != ST_SKIPPED);

   // hold a stalled response word
   `TCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid)
   `TCT_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_word))

   // the clearing pass blocks requests right after reset
   `TCT_ASSERT_IMP(a_clear_after_reset, clock, reset, $fell(reset), req_stall)

   // errors and skips never carry a count
   `TCT_ASSERT_IMP(a_err_no_count, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_count == '0)

   // only a checked failure can report a rollback
   `TCT_ASSERT_IMP(a_revert_status, clock, reset, rsp_valid && rsp_batch_reverted, rsp_fail)

endmodule

bind transactional_counter_table tct_checker u_checker (.*);

### test/tb_transactional_counter_table.sv
`timescale 1ns / 1ps

module tb_transactional_counter_table;
   import tct_pkg::*;

   // Run limit. The worst case covers the clearing pass after reset, every clear
   // walking the whole store, a full journal rollback, and every word meeting the
   // longest sender gap plus the longest response stall. That total is then taken
   // several times over.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_CYCLES = 40;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [CMD_W-1:0]            req_command;
   logic [TYPE_W-1:0]           req_type_number;
   logic [TERM_W-1:0]           req_term_number;
   logic signed [VALUE_W-1:0]   req_increment_value;
   logic                        req_batch_last;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic signed [VALUE_W-1:0]   rsp_count;
   logic                        rsp_batch_reverted;

   transactional_counter_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_type_number     (req_type_number),
      .req_term_number     (req_term_number),
      .req_increment_value (req_increment_value),
      .req_batch_last      (req_batch_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_count           (rsp_count),
      .rsp_batch_reverted  (rsp_batch_reverted)
   );

   // One response word as the table should produce it.
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  count;
      logic                reverted;
   } outcome_type;

   // One logged increment of the open batch: the counter slot and the amount added.
   typedef struct {
      int unsigned         slot;
      logic [VALUE_W-1:0]  amount;
   } ledger_type;

   // Shadow copy of the table state.
   logic [VALUE_W-1:0] tally [STORE_DEPTH];
   ledger_type         open_ledger[$];
   bit                 skip_rest;

   // Responses still owed by the table, oldest first.
   outcome_type        owed_outcomes[$];
   outcome_type        due;

   int                 mismatch_count;
   int                 words_sent;
   int                 cycle_count = 0;
   int                 clears_left;
   int                 stall_left = 0;
   bit                 steady_tail;

   // Clock: 12 ns period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Resolve a (type, term) pair to a counter slot, or to the error that stops it.
   function automatic logic [STATUS_W-1:0] locate_counter(
      input  logic [TYPE_W-1:0] kind,
      input  logic [TERM_W-1:0] term,
      output int unsigned       slot
   );
      slot = 0;
      if (kind == '0 || int'(kind) > TERM_TYPES)
         return ST_TYPE_RANGE;
      if (term == '0)
         return ST_TERM_ZERO;
      if (int'(term) > TERMS_PER_TYPE)
         return ST_TERM_CAP;
      slot = (int'(kind) - 1) * TERMS_PER_TYPE + int'(term) - 1;
      return ST_OK;
   endfunction

   // Apply one accepted request word to the shadow table and return the response
   // it must produce.
   function automatic outcome_type predict_word(
      input logic [CMD_W-1:0]   cmd,
      input logic [TYPE_W-1:0]  kind,
      input logic [TERM_W-1:0]  term,
      input logic [VALUE_W-1:0] amount,
      input logic               last
   );
      outcome_type         res;
      int unsigned         slot;
      logic [STATUS_W-1:0] verdict;
      res.status   = ST_OK;
      res.count    = '0;
      res.reverted = 1'b0;
      case (cmd)
         CMD_INC: begin
            if (skip_rest) begin
               // Drop the rest of a failed batch up to and including its last word.
               res.status = ST_SKIPPED;
               if (last)
                  skip_rest = 1'b0;
            end else begin
               verdict = locate_counter(kind, term, slot);
               if (verdict == ST_OK && open_ledger.size() >= BATCH_MAX)
                  verdict = ST_JOURNAL_FULL;
               res.status = verdict;
               if (verdict != ST_OK) begin
                  // Undo every increment logged so far in this batch.
                  res.reverted = (open_ledger.size() != 0);
                  foreach (open_ledger[i])
                     tally[open_ledger[i].slot] -= open_ledger[i].amount;
                  open_ledger.delete();
                  if (!last)
                     skip_rest = 1'b1;
               end else begin
                  tally[slot] += amount;
                  if (last)
                     open_ledger.delete();
                  else
                     open_ledger.push_back('{slot, amount});
               end
            end
         end
         CMD_QUERY: begin
            verdict = locate_counter(kind, term, slot);
            // Beyond capacity reads as zero with an ok status.
            if (verdict == ST_TYPE_RANGE || verdict == ST_TERM_ZERO)
               res.status = verdict;
            else if (verdict == ST_OK)
               res.count = tally[slot];
         end
         CMD_CLEAR: begin
            // Clear leaves the skip state alone but forgets the open batch.
            foreach (tally[i])
               tally[i] = '0;
            open_ledger.delete();
         end
         default: ;
      endcase
      return res;
   endfunction

   // Scoreboard: predict on every accepted request word, then check every accepted
   // response word against the oldest prediction. Prediction runs first so a
   // response in the same cycle still finds its entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            owed_outcomes.push_back(predict_word(req_command, req_type_number,
               req_term_number, req_increment_value, req_batch_last));
         if (rsp_valid && !rsp_stall) begin
            if (owed_outcomes.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               due = owed_outcomes.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, due.status));
               if (rsp_count !== due.count)
                  report_mismatch($sformatf("count %h, want %h", rsp_count, due.count));
               if (rsp_batch_reverted !== due.reverted)
                  report_mismatch($sformatf("batch_reverted %b, want %b",
                     rsp_batch_reverted, due.reverted));
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response backpressure: stall in random bursts in three stretches out of every
   // four, with none in the first of each four and none at all in the steady tail.
   always @(posedge clock) begin
      if (reset || steady_tail) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (((cycle_count / 1500) % 4) != 0 && $urandom_range(0, 9) == 0)
            stall_left <= int'($urandom_range(1, 15));
      end
   end

   // Send one request word and return right after the edge that accepts it.
   // Valid stays high into the next word unless a gap is drawn.
   task automatic send_word(
      input logic [CMD_W-1:0]   cmd,
      input logic [TYPE_W-1:0]  kind,
      input logic [TERM_W-1:0]  term,
      input logic [VALUE_W-1:0] amount,
      input logic               last
   );
      if (!steady_tail && ((words_sent / 160) % 4) != 0 && $urandom_range(0, 5) == 0) begin
         // Idle the request side for a burst, with junk on the payload.
         req_valid           <= 1'b0;
         req_command         <= CMD_W'($urandom());
         req_type_number     <= TYPE_W'($urandom());
         req_term_number     <= TERM_W'($urandom());
         req_increment_value <= $urandom();
         req_batch_last      <= 1'($urandom());
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_type_number     <= kind;
      req_term_number     <= term;
      req_increment_value <= amount;
      req_batch_last      <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // Send a word with raw noise on every field but the command.
   task automatic send_noise_word(input logic [CMD_W-1:0] cmd);
      send_word(cmd, TYPE_W'($urandom()), TERM_W'($urandom()), $urandom(), 1'($urandom()));
   endtask

   // Field pickers. Valid addresses favor a small hot set so that queries and
   // rollbacks land on counters that were written.
   function automatic logic [TYPE_W-1:0] pick_kind();
      return TYPE_W'($urandom_range(1, TERM_TYPES));
   endfunction

   function automatic logic [TERM_W-1:0] pick_term();
      case ($urandom_range(0, 4))
         0: return TERM_W'(1);
         1: return TERM_W'(TERMS_PER_TYPE);
         2: return TERM_W'(TERMS_PER_TYPE - 1);
         3: return TERM_W'($urandom_range(1, 4));
         default: return TERM_W'($urandom_range(1, TERMS_PER_TYPE));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_amount();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 20)) - 32'd10;
         default: return $urandom();
      endcase
   endfunction

   // Send an increment that fails its address check.
   task automatic send_faulty_increment(input logic last);
      case ($urandom_range(0, 3))
         0: send_word(CMD_INC, '0, pick_term(), pick_amount(), last);
         1: send_word(CMD_INC, TYPE_W'($urandom_range(TERM_TYPES + 1, 255)),
               TERM_W'($urandom()), pick_amount(), last);
         2: send_word(CMD_INC, pick_kind(), '0, pick_amount(), last);
         default: send_word(CMD_INC, pick_kind(),
               TERM_W'($urandom_range(TERMS_PER_TYPE + 1, (1 << TERM_W) - 1)),
               pick_amount(), last);
      endcase
   endtask

   // Extremes of every field, each status code but journal full, rollback, skipping and clear.
   task automatic test_directed_cases();
      send_word(CMD_QUERY, 8'd1, 20'd1, '0, 1'b0);
      // Wrap at the top of the signed range.
      send_word(CMD_INC, 8'd1, 20'd1, 32'h7FFF_FFFF, 1'b1);
      send_word(CMD_INC, 8'd1, 20'd1, 32'd1, 1'b1);
      send_word(CMD_QUERY, 8'd1, 20'd1, '0, 1'b0);
      // Highest counter, two-word batch.
      send_word(CMD_INC, TYPE_W'(TERM_TYPES), TERM_W'(TERMS_PER_TYPE), 32'hFFFF_FFFF, 1'b0);
      send_word(CMD_INC, TYPE_W'(TERM_TYPES), TERM_W'(TERMS_PER_TYPE), 32'h8000_0000, 1'b1);
      send_word(CMD_QUERY, TYPE_W'(TERM_TYPES), TERM_W'(TERMS_PER_TYPE), '0, 1'b0);
      // Query errors: type is checked before term; over capacity reads zero.
      send_word(CMD_QUERY, 8'd0, 20'd5, '0, 1'b0);
      send_word(CMD_QUERY, 8'd255, 20'd0, '0, 1'b0);
      send_word(CMD_QUERY, 8'd3, 20'd0, '0, 1'b0);
      send_word(CMD_QUERY, 8'd3, TERM_W'(TERMS_PER_TYPE + 1), '0, 1'b0);
      send_word(CMD_QUERY, 8'd3, 20'hF_FFFF, '0, 1'b0);
      // Lone failing last word: nothing to revert, no skipping afterwards.
      send_word(CMD_INC, 8'd0, 20'd1, 32'd5, 1'b1);
      // Failure after two logged increments: revert, then skip to the batch end.
      send_word(CMD_INC, 8'd2, 20'd5, 32'd100, 1'b0);
      send_word(CMD_INC, 8'd2, 20'd6, 32'd200, 1'b0);
      send_word(CMD_INC, 8'd2, 20'd0, 32'd1, 1'b0);
      send_word(CMD_INC, 8'd2, 20'd7, 32'd1, 1'b0);
      send_word(CMD_INC, 8'd2, 20'd7, 32'd1, 1'b1);
      send_word(CMD_QUERY, 8'd2, 20'd5, '0, 1'b0);
      // Over-capacity failure on the first word of a batch.
      send_word(CMD_INC, 8'd4, TERM_W'(TERMS_PER_TYPE + 1), 32'd3, 1'b0);
      send_word(CMD_INC, 8'd4, 20'd1, 32'd3, 1'b1);
      send_noise_word(CMD_NOP);
      // Clear inside an open batch: the logged increment can no longer be reverted.
      send_word(CMD_INC, 8'd5, 20'd9, 32'd7, 1'b0);
      send_word(CMD_CLEAR, TYPE_W'($urandom()), TERM_W'($urandom()), $urandom(), 1'b0);
      send_word(CMD_INC, 8'd5, 20'd0, 32'd1, 1'b1);
      send_word(CMD_QUERY, 8'd5, 20'd9, '0, 1'b0);
      // Clear while skipping: skipping carries on.
      send_word(CMD_INC, 8'd1, 20'd0, 32'd1, 1'b0);
      send_word(CMD_CLEAR, TYPE_W'($urandom()), TERM_W'($urandom()), $urandom(), 1'b1);
      send_word(CMD_INC, 8'd1, 20'd1, 32'd1, 1'b1);
   endtask

   // Fill the journal exactly and commit, then overflow it by one word.
   task automatic test_journal_limits();
      for (int i = 0; i < BATCH_MAX; i++)
         send_word(CMD_INC, pick_kind(), pick_term(), pick_amount(), i == BATCH_MAX - 1);
      send_word(CMD_QUERY, pick_kind(), pick_term(), '0, 1'b0);
      for (int i = 0; i < BATCH_MAX; i++)
         send_word(CMD_INC, pick_kind(), pick_term(), pick_amount(), 1'b0);
      // Valid address, full journal: revert all BATCH_MAX entries.
      send_word(CMD_INC, pick_kind(), pick_term(), pick_amount(), 1'b0);
      send_word(CMD_INC, pick_kind(), pick_term(), pick_amount(), 1'b1);
      repeat (4) send_word(CMD_QUERY, pick_kind(), pick_term(), '0, 1'b0);
   endtask

   // Mostly well-formed batches with random content, some with a failing word,
   // mixed with queries, rare clears and raw noise on every field.
   task automatic test_random_traffic(input int words);
      int goal;
      int pick;
      int len;
      int bad_at;
      goal = words_sent + words;
      while (words_sent < goal) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 65) begin
            len    = int'($urandom_range(1, 12));
            bad_at = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, len - 1)) : -1;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 6) == 0)
                  send_word(CMD_QUERY, pick_kind(), pick_term(), $urandom(), 1'($urandom()));
               if (i == bad_at)
                  send_faulty_increment(i == len - 1);
               else
                  send_word(CMD_INC, pick_kind(), pick_term(), pick_amount(), i == len - 1);
            end
            if ($urandom_range(0, 2) == 0)
               send_word(CMD_QUERY, pick_kind(), pick_term(), $urandom(), 1'($urandom()));
         end else if (pick < 85) begin
            send_word(CMD_QUERY, pick_kind(), pick_term(), $urandom(), 1'($urandom()));
         end else if (pick < 88) begin
            send_noise_word(CMD_NOP);
         end else if (pick < 89 && clears_left > 0) begin
            // Each clear walks the whole store, so hold them to a small budget.
            clears_left--;
            send_noise_word(CMD_CLEAR);
         end else begin
            send_noise_word(($urandom_range(0, 1) != 0) ? CMD_INC : CMD_QUERY);
         end
      end
   endtask

   // Last stretch at full rate: no gaps and no stalls.
   task automatic test_steady_tail(input int words);
      steady_tail = 1'b1;
      test_random_traffic(words);
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = CMD_NOP;
      req_type_number     = '0;
      req_term_number     = '0;
      req_increment_value = '0;
      req_batch_last      = 1'b0;
      mismatch_count      = 0;
      words_sent          = 0;
      clears_left         = 5;
      steady_tail         = 1'b0;
      skip_rest           = 1'b0;
      foreach (tally[i])
         tally[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The table holds req_stall through its clearing pass; send_word waits it out.
      test_directed_cases();
      test_journal_limits();
      test_random_traffic(1150);
      test_steady_tail(200);

      // Drain: drop valid, wait for every owed response, then watch for strays.
      req_valid <= 1'b0;
      while (owed_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (owed_outcomes.size() != 0)
         report_mismatch("responses still owed at end of run");

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/tct_pkg.sv
design/tct_ram.sv
design/tct_ctrl.sv
design/transactional_counter_table.sv
design/tct_checker.sv
test/tb_transactional_counter_table.sv
